// ===== src/crdg_pkg.sv =====
// Shared constants and types for the camera ray direction generator.
package crdg_pkg;

   // Screen resolution used for the pixel offsets.
   localparam int COLUMNS = 256;
   localparam int ROWS    = 256;

   // Signed width of 2*index - resolution.
   localparam int MAX_RES = (COLUMNS > ROWS) ? COLUMNS : ROWS;
   localparam int OFS_W   = ($clog2(MAX_RES) + 2 > 10) ? $clog2(MAX_RES) + 2 : 10;
   // Offset times screen size, then times a basis component.
   localparam int A_W     = OFS_W + 17;
   localparam int P_W     = A_W + 16;
   // Focal distance times a basis component.
   localparam int PF_W    = 33;
   // Scale of the forward term and width of the exact direction.
   localparam int SCALE_F = 2 * COLUMNS * ROWS;
   localparam int E_W     = 34 + $clog2(SCALE_F);
   localparam int SH_W    = $clog2(E_W + 1);
   // Normalization datapath widths.
   localparam int V_W     = 30;
   localparam int SQ_W    = 2 * V_W + 2;
   localparam int N_W     = V_W + 1;
   localparam int Q_W     = 15;
   localparam int NUM_W   = V_W + Q_W + 1;
   localparam int DEN_W   = N_W + 1;
   localparam int ROOT_STEPS = SQ_W / 2;
   localparam int DIV_STEPS  = Q_W;
   localparam int OUT_MAX    = 16384;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_FORWARD  = 3'd0,
      CSR_RIGHT    = 3'd1,
      CSR_UP       = 3'd2,
      CSR_FOCAL    = 3'd3,
      CSR_WIDTH    = 3'd4,
      CSR_HEIGHT   = 3'd5
   } csr_index_type;

   // Data that travels beside the square root.
   typedef struct packed {
      logic [2:0][V_W-1:0] mag;
      logic [2:0]          neg;
      logic                zero;
   } root_side_type;

   // Data that travels beside the divider.
   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } div_side_type;

endpackage

// ===== src/camera_ray_direction_generator_core.sv =====
// Top level of the camera ray direction generator.
// Each request passes through the front-end stages, the root pipe, the divider pipe and the output register.
// Throughput: one transaction per cycle while no stalled response holds the pipe; the
// full-width multiply, root and divide pipes each take a new item every cycle.
// A stalled response freezes every stage of the pipe at once.
// Reset (synchronous) clears all valid bits and loads the default camera basis.
module camera_ray_direction_generator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_pixel_col,
   input  logic [7:0]         req_pixel_row,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic signed [15:0] rsp_dir_z,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data
);
   import crdg_pkg::*;

   logic [47:0] forward_ff, right_ff, up_ff;
   logic [15:0] focal_ff, width_ff, height_ff;
   logic        advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         forward_ff <= 48'd16384;
         right_ff   <= 48'd1073741824;
         up_ff      <= 48'd70368744177664;
         focal_ff   <= 16'd256;
         width_ff   <= 16'd256;
         height_ff  <= 16'd256;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FORWARD: forward_ff <= csr_data;
            CSR_RIGHT:   right_ff   <= csr_data;
            CSR_UP:      up_ff      <= csr_data;
            CSR_FOCAL:   focal_ff   <= csr_data[15:0];
            CSR_WIDTH:   width_ff   <= csr_data[15:0];
            CSR_HEIGHT:  height_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // The pipe moves whenever the output register is free or being drained.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Stage 1: pixel offsets times screen sizes, focal distance times forward.
   logic signed [OFS_W-1:0]  ofs_c, ofs_r;
   logic                     s1_valid_ff;
   logic signed [A_W-1:0]    s1_a_ff, s1_b_ff;
   logic signed [PF_W-1:0]   s1_pf_ff [3];

   assign ofs_c = OFS_W'({req_pixel_col, 1'b0}) - OFS_W'(COLUMNS);
   assign ofs_r = OFS_W'({req_pixel_row, 1'b0}) - OFS_W'(ROWS);

   // Stage 2: screen terms times right and up components.
   logic                     s2_valid_ff;
   logic signed [P_W-1:0]    s2_pr_ff [3];
   logic signed [P_W-1:0]    s2_pu_ff [3];
   logic signed [PF_W-1:0]   s2_pf_ff [3];

   // Stage 3: exact direction.
   localparam logic signed [E_W-1:0] SCALE_F_E = E_W'(SCALE_F);
   localparam logic signed [E_W-1:0] SCALE_R_E = E_W'(ROWS);
   localparam logic signed [E_W-1:0] SCALE_U_E = E_W'(COLUMNS);
   logic                     s3_valid_ff;
   logic signed [E_W-1:0]    s3_e_ff [3];

   // Stage 4: magnitudes, signs and their common leading-one word.
   logic                     s4_valid_ff;
   logic [E_W-1:0]           s4_mag_ff [3];
   logic [2:0]               s4_neg_ff;
   logic [E_W-1:0]           s4_or_ff;

   // Stage 5: normalizing shift count.
   logic                     s5_valid_ff;
   logic [E_W-1:0]           s5_mag_ff [3];
   logic [2:0]               s5_neg_ff;
   logic [SH_W-1:0]          s5_shift_ff;
   logic [SH_W-1:0]          shift_in;

   // Stage 6: shifted magnitudes.
   logic                     s6_valid_ff;
   logic [V_W-1:0]           s6_v_ff [3];
   logic [2:0]               s6_neg_ff;

   // Stage 7: squares.
   logic                     s7_valid_ff;
   logic [V_W-1:0]           s7_v_ff [3];
   logic [2:0]               s7_neg_ff;
   logic [2*V_W-1:0]         s7_sq_ff [3];

   // Stage 8: sum of squares.
   logic                     s8_valid_ff;
   logic [SQ_W-1:0]          s8_sum_ff;
   root_side_type            s8_side_ff;

   // Leading-one search gives the shift that brings the largest value below 2^30.
   always_comb begin
      logic [SH_W-1:0] lead;
      lead = '0;
      for (int i = 0; i < E_W; i++) begin
         if (s4_or_ff[i]) lead = SH_W'(i + 1);
      end
      shift_in = (lead > SH_W'(V_W)) ? lead - SH_W'(V_W) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
      end
   end

   // Front-end datapath registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_a_ff <= A_W'(ofs_c * $signed({1'b0, width_ff}));
         s1_b_ff <= A_W'(ofs_r * $signed({1'b0, height_ff}));
         for (int k = 0; k < 3; k++) begin
            s1_pf_ff[k] <= PF_W'($signed({1'b0, focal_ff}) * $signed(forward_ff[16*k +: 16]));
            s2_pr_ff[k] <= P_W'(s1_a_ff * $signed(right_ff[16*k +: 16]));
            s2_pu_ff[k] <= P_W'(s1_b_ff * $signed(up_ff[16*k +: 16]));
            s2_pf_ff[k] <= s1_pf_ff[k];
            s3_e_ff[k]  <= E_W'(s2_pf_ff[k]) * SCALE_F_E
                         + E_W'(s2_pr_ff[k]) * SCALE_R_E
                         + E_W'(s2_pu_ff[k]) * SCALE_U_E;
            s4_mag_ff[k] <= s3_e_ff[k][E_W-1] ? E_W'(-s3_e_ff[k]) : E_W'(s3_e_ff[k]);
            s4_neg_ff[k] <= s3_e_ff[k][E_W-1];
            s5_mag_ff[k] <= s4_mag_ff[k];
            s6_v_ff[k]   <= V_W'(s5_mag_ff[k] >> s5_shift_ff);
            s7_v_ff[k]   <= s6_v_ff[k];
            s7_sq_ff[k]  <= s6_v_ff[k] * s6_v_ff[k];
         end
         s4_or_ff    <= E_W'(s3_e_ff[0][E_W-1] ? -s3_e_ff[0] : s3_e_ff[0])
                      | E_W'(s3_e_ff[1][E_W-1] ? -s3_e_ff[1] : s3_e_ff[1])
                      | E_W'(s3_e_ff[2][E_W-1] ? -s3_e_ff[2] : s3_e_ff[2]);
         s5_neg_ff   <= s4_neg_ff;
         s5_shift_ff <= shift_in;
         s6_neg_ff   <= s5_neg_ff;
         s7_neg_ff   <= s6_neg_ff;
         s8_sum_ff   <= SQ_W'(s7_sq_ff[0]) + SQ_W'(s7_sq_ff[1]) + SQ_W'(s7_sq_ff[2]);
         s8_side_ff.mag[0] <= s7_v_ff[0];
         s8_side_ff.mag[1] <= s7_v_ff[1];
         s8_side_ff.mag[2] <= s7_v_ff[2];
         s8_side_ff.neg    <= s7_neg_ff;
         s8_side_ff.zero   <= (s7_sq_ff[0] == '0) && (s7_sq_ff[1] == '0)
                           && (s7_sq_ff[2] == '0);
      end
   end

   // Square root of the sum of squares.
   logic                root_valid;
   logic [N_W-1:0]      root_val;
   root_side_type       root_side;

   crdg_root u_root (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s8_valid_ff),
      .in_sum    (s8_sum_ff),
      .in_side   (s8_side_ff),
      .out_valid (root_valid),
      .out_root  (root_val),
      .out_side  (root_side)
   );

   // Rounded quotients of each magnitude by the root.
   logic                div_valid;
   logic [2:0][Q_W-1:0] div_quo;
   div_side_type        div_side;

   crdg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (root_valid),
      .in_root   (root_val),
      .in_side   (root_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // Saturation, sign and the zero-length case go into the output register.
   logic              rsp_valid_ff;
   logic signed [15:0] dir_ff [3];
   logic signed [15:0] dir_in [3];

   always_comb begin
      logic [15:0] q;
      for (int k = 0; k < 3; k++) begin
         q = (16'(div_quo[k]) > 16'(OUT_MAX)) ? 16'(OUT_MAX) : 16'(div_quo[k]);
         if (div_side.zero) dir_in[k] = '0;
         else if (div_side.neg[k]) dir_in[k] = -$signed(q);
         else dir_in[k] = $signed(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) dir_ff[k] <= dir_in[k];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dir_x = dir_ff[0];
   assign rsp_dir_y = dir_ff[1];
   assign rsp_dir_z = dir_ff[2];

endmodule

// ===== src/crdg_root.sv =====
// Pipelined integer square root, one result bit per stage.
module crdg_root (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [crdg_pkg::SQ_W-1:0]    in_sum,
   input  crdg_pkg::root_side_type      in_side,
   output logic                         out_valid,
   output logic [crdg_pkg::N_W-1:0]     out_root,
   output crdg_pkg::root_side_type      out_side
);
   import crdg_pkg::*;

   logic          valid_ff [ROOT_STEPS];
   logic [SQ_W-1:0] x_ff   [ROOT_STEPS];
   logic [SQ_W-1:0] x_in   [ROOT_STEPS];
   logic [SQ_W-1:0] res_ff [ROOT_STEPS];
   logic [SQ_W-1:0] res_in [ROOT_STEPS];
   root_side_type side_ff  [ROOT_STEPS];

   // Each stage tries one bit pair of the root.
   always_comb begin
      logic [SQ_W-1:0] xp;
      logic [SQ_W-1:0] rp;
      logic [SQ_W-1:0] bv;
      logic [SQ_W-1:0] tr;
      for (int i = 0; i < ROOT_STEPS; i++) begin
         xp = (i == 0) ? in_sum : x_ff[(i == 0) ? 0 : i - 1];
         rp = (i == 0) ? '0 : res_ff[(i == 0) ? 0 : i - 1];
         bv = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - i));
         tr = rp + bv;
         if (xp >= tr) begin
            x_in[i]   = xp - tr;
            res_in[i] = (rp >> 1) + bv;
         end else begin
            x_in[i]   = xp;
            res_in[i] = rp >> 1;
         end
      end
   end

   // Stage registers; the whole pipe holds while advance is low.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_STEPS; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < ROOT_STEPS; i++) begin
            valid_ff[i] <= (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < ROOT_STEPS; i++) begin
            x_ff[i]    <= x_in[i];
            res_ff[i]  <= res_in[i];
            side_ff[i] <= (i == 0) ? in_side : side_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_STEPS-1];
   assign out_root  = res_ff[ROOT_STEPS-1][N_W-1:0];
   assign out_side  = side_ff[ROOT_STEPS-1];

endmodule

// ===== src/crdg_div.sv =====
// Pipelined restoring divider that scales three magnitudes by the root.
module crdg_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [crdg_pkg::N_W-1:0]       in_root,
   input  crdg_pkg::root_side_type        in_side,
   output logic                           out_valid,
   output logic [2:0][crdg_pkg::Q_W-1:0]  out_quo,
   output crdg_pkg::div_side_type         out_side
);
   import crdg_pkg::*;

   logic                      valid_ff [DIV_STEPS];
   logic [2:0][NUM_W-1:0]     rem_ff   [DIV_STEPS];
   logic [2:0][NUM_W-1:0]     rem_in   [DIV_STEPS];
   logic [2:0][Q_W-1:0]       quo_ff   [DIV_STEPS];
   logic [2:0][Q_W-1:0]       quo_in   [DIV_STEPS];
   logic [DEN_W-1:0]          den_ff   [DIV_STEPS];
   logic [DEN_W-1:0]          den_in   [DIV_STEPS];
   div_side_type              side_ff  [DIV_STEPS];
   div_side_type              side_in;

   assign side_in.neg  = in_side.neg;
   assign side_in.zero = in_side.zero;

   // Numerator is mag*2^15 + n, divisor 2n; each stage settles one quotient bit.
   always_comb begin
      logic [2:0][NUM_W-1:0] rp;
      logic [2:0][Q_W-1:0]   qp;
      logic [DEN_W-1:0]      dp;
      logic [NUM_W-1:0]      tr;
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (i == 0) begin
            for (int k = 0; k < 3; k++) begin
               rp[k] = (NUM_W'(in_side.mag[k]) << Q_W) + NUM_W'(in_root);
            end
            qp = '0;
            dp = {in_root, 1'b0};
         end else begin
            rp = rem_ff[(i == 0) ? 0 : i - 1];
            qp = quo_ff[(i == 0) ? 0 : i - 1];
            dp = den_ff[(i == 0) ? 0 : i - 1];
         end
         tr = NUM_W'(dp) << (DIV_STEPS - 1 - i);
         for (int k = 0; k < 3; k++) begin
            if (rp[k] >= tr) begin
               rem_in[i][k] = rp[k] - tr;
               quo_in[i][k] = qp[k] | (Q_W'(1) << (DIV_STEPS - 1 - i));
            end else begin
               rem_in[i][k] = rp[k];
               quo_in[i][k] = qp[k];
            end
         end
         den_in[i] = dp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            valid_ff[i] <= (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            rem_ff[i]  <= rem_in[i];
            quo_ff[i]  <= quo_in[i];
            den_ff[i]  <= den_in[i];
            side_ff[i] <= (i == 0) ? side_in : side_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quo   = quo_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

// ===== src/crdg_checker.sv =====
// Port-level checks for the camera ray direction generator, bound to the top level.
module crdg_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_stall,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_dir_x,
   input  logic signed [15:0] rsp_dir_y,
   input  logic signed [15:0] rsp_dir_z
);

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_dir_x) && $stable(rsp_dir_y)
                                 && $stable(rsp_dir_z))
      else $error("response payload changed while stalled");

   // The request side is held back only by a waiting, stalled response.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without back-pressure");

   // Reset leaves no response pending.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Unit direction components never leave the Q1.14 unit range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dir_x >= -16'sd16384 && rsp_dir_x <= 16'sd16384
                 && rsp_dir_y >= -16'sd16384 && rsp_dir_y <= 16'sd16384
                 && rsp_dir_z >= -16'sd16384 && rsp_dir_z <= 16'sd16384)
      else $error("direction component out of range");

endmodule

bind camera_ray_direction_generator_core crdg_checker u_crdg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_dir_x (rsp_dir_x),
   .rsp_dir_y (rsp_dir_y),
   .rsp_dir_z (rsp_dir_z)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the camera ray direction generator core.
`timescale 1ns / 1ps

module tb_top;
   import crdg_pkg::*;

   // Indexes past the register list; writes to them must be ignored.
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam int DRAIN_CYCLES = 70;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 56;

   // One predicted ray, kept with its pixel for messages.
   typedef struct {
      logic signed [15:0] dir [3];
      logic [7:0]         col;
      logic [7:0]         row;
   } ray_expect_type;

   // Predicts ray directions and checks the responses in order.
   class ray_scoreboard;
      logic [47:0] forward_vec, right_vec, up_vec;
      logic [15:0] focal, width, height;
      ray_expect_type pending_rays[$];
      int errors, checked, zero_rays, saturated;

      function new();
         forward_vec = 48'd16384;
         right_vec   = 48'd1073741824;
         up_vec      = 48'd70368744177664;
         focal  = 16'd256;
         width  = 16'd256;
         height = 16'd256;
      endfunction

      function void set_reg(logic [2:0] idx, logic [47:0] data);
         case (idx)
            CSR_FORWARD: forward_vec = data;
            CSR_RIGHT:   right_vec   = data;
            CSR_UP:      up_vec      = data;
            CSR_FOCAL:   focal  = data[15:0];
            CSR_WIDTH:   width  = data[15:0];
            CSR_HEIGHT:  height = data[15:0];
            default: ;
         endcase
      endfunction

      function longint axis_part(logic [47:0] v, int k);
         logic signed [15:0] t;
         t = v[16*k +: 16];
         return longint'(t);
      endfunction

      // Integer square root, one result bit per pass.
      function longint unsigned root_floor(longint unsigned x);
         longint unsigned acc, bitpos;
         acc = 0;
         bitpos = 64'd1 << 62;
         while (bitpos > x) bitpos >>= 2;
         while (bitpos != 0) begin
            if (x >= acc + bitpos) begin
               x   = x - (acc + bitpos);
               acc = (acc >> 1) + bitpos;
            end else begin
               acc = acc >> 1;
            end
            bitpos >>= 2;
         end
         return acc;
      endfunction

      // Note an accepted pixel transaction and queue its expected ray.
      function void note_pixel(logic [7:0] col, logic [7:0] row);
         longint kf, kr, ku, e;
         longint unsigned mag [3];
         longint unsigned mx, sum, n, q;
         bit neg [3];
         int s;
         ray_expect_type r;
         kf = longint'(focal) * 2 * COLUMNS * ROWS;
         kr = (2 * longint'(col) - COLUMNS) * longint'(width) * ROWS;
         ku = (2 * longint'(row) - ROWS) * longint'(height) * COLUMNS;
         mx = 0;
         sum = 0;
         s = 0;
         for (int k = 0; k < 3; k++) begin
            e = kf * axis_part(forward_vec, k) + kr * axis_part(right_vec, k)
                + ku * axis_part(up_vec, k);
            neg[k] = e < 0;
            mag[k] = neg[k] ? longint'(-e) : e;
            if (mag[k] > mx) mx = mag[k];
         end
         while ((mx >> s) >= (64'd1 << 30)) s++;
         for (int k = 0; k < 3; k++) begin
            mag[k] = mag[k] >> s;
            sum += mag[k] * mag[k];
         end
         r.col = col;
         r.row = row;
         if (sum == 0) begin
            for (int k = 0; k < 3; k++) r.dir[k] = '0;
            zero_rays++;
         end else begin
            n = root_floor(sum);
            for (int k = 0; k < 3; k++) begin
               q = (mag[k] * 32768 + n) / (2 * n);
               if (q > OUT_MAX) q = OUT_MAX;
               if (q == OUT_MAX) saturated++;
               r.dir[k] = neg[k] ? -16'(q) : 16'(q);
            end
         end
         pending_rays = {pending_rays, r};
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      // Compare one accepted response with the oldest expectation.
      task check_ray(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
         ray_expect_type r;
         logic signed [15:0] got [3];
         got = '{x, y, z};
         if (pending_rays.size() == 0) begin
            report_mismatch($sformatf("unexpected response %0d %0d %0d", x, y, z));
         end else begin
            r = pending_rays.pop_front();
            checked++;
            for (int k = 0; k < 3; k++)
               if (got[k] !== r.dir[k])
                  report_mismatch($sformatf("pixel (%0d,%0d) component %0d: got %0d want %0d",
                                            r.col, r.row, k, got[k], r.dir[k]));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_pixel_col = '0;
   logic [7:0] req_pixel_row = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [47:0] csr_data = '0;

   ray_scoreboard rays = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;

   camera_ray_direction_generator_core DUT (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Receiver stall, including the long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         rays.check_ray(rsp_dir_x, rsp_dir_y, rsp_dir_z);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   task send_pixel(logic [7:0] col, logic [7:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_pixel_col = col;
      req_pixel_row = row;
      do @(posedge clock); while (req_stall);
      rays.note_pixel(col, row);
   endtask

   task write_csr(logic [2:0] idx, logic [47:0] data);
      @(negedge clock);
      req_valid = 1'b0;
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      rays.set_reg(idx, data);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (rays.pending_rays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random basis vector: an axis-aligned unit vector or arbitrary bits.
   function logic [47:0] random_basis();
      logic [47:0] v;
      int slot;
      if ($urandom_range(2) == 0) begin
         v = 48'({$urandom(), $urandom()});
      end else begin
         slot = $urandom_range(2);
         v = '0;
         v[16*slot +: 16] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      end
      return v;
   endfunction

   function logic [15:0] random_size();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: default camera at the screen corners, the center and an edge midpoint.
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd0, 8'd255);
      send_pixel(8'd255, 8'd0);
      send_pixel(8'd128, 8'd128);
      send_pixel(8'd128, 8'd0);

      // Zero-length direction: no distance with the center pixel, then zero screen sizes too.
      wait_drained();
      write_csr(CSR_FOCAL, 48'd0);
      send_pixel(8'd128, 8'd128);
      send_pixel(8'd0, 8'd128);
      wait_drained();
      write_csr(CSR_WIDTH, 48'd0);
      write_csr(CSR_HEIGHT, 48'd0);
      send_pixel(8'd17, 8'd200);
      send_pixel(8'd255, 8'd255);

      // Extremes: sizes and distance at their top, basis at extreme bit patterns, high bits ignored.
      wait_drained();
      write_csr(CSR_FORWARD, 48'hFFFF_FFFF_FFFF);
      write_csr(CSR_RIGHT, 48'h7FFF_7FFF_7FFF);
      write_csr(CSR_UP, 48'h8000_8000_8000);
      write_csr(CSR_FOCAL, 48'hFFFF_FFFF_FFFF);
      write_csr(CSR_WIDTH, 48'hFFFF_FFFF_FFFF);
      write_csr(CSR_HEIGHT, 48'hFFFF_FFFF_FFFF);
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd0, 8'd255);
      send_pixel(8'd255, 8'd0);

      // Writes past the register list leave the camera unchanged.
      wait_drained();
      write_csr(CSR_SPARE_LO, 48'hFFFF_FFFF_FFFF);
      write_csr(CSR_SPARE_HI, 48'h1234_5678_9ABC);
      send_pixel(8'd64, 8'd192);
      send_pixel(8'd200, 8'd30);

      // Random phases, cycling through the idling modes; the last phase uses a fixed extreme camera.
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         if (phase == 7) begin
            write_csr(CSR_FORWARD, 48'h8000_8000_8000);
            write_csr(CSR_RIGHT, 48'hFFFF_FFFF_FFFF);
            write_csr(CSR_UP, 48'h7FFF_7FFF_7FFF);
            write_csr(CSR_FOCAL, 48'd1);
            write_csr(CSR_WIDTH, 48'hFFFF);
            write_csr(CSR_HEIGHT, 48'd0);
         end else begin
            write_csr(CSR_FORWARD, random_basis());
            write_csr(CSR_RIGHT, random_basis());
            write_csr(CSR_UP, random_basis());
            write_csr(CSR_FOCAL, {32'($urandom()), random_size()});
            write_csr(CSR_WIDTH, {32'($urandom()), random_size()});
            write_csr(CSR_HEIGHT, {32'($urandom()), random_size()});
         end
         if ($urandom_range(3) == 0)
            write_csr($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      48'({$urandom(), $urandom()}));
         // Long receiver hold-off so the pipe fills and stalls its input.
         if (phase == 0) hold_cycles = 300;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_pixel(8'($urandom()), 8'($urandom()));
      end

      wait_drained();
      $display("checked %0d rays over corner, zero-length, saturating and random cameras",
               rays.checked);
      $display("%0d zero-length rays, %0d saturated components", rays.zero_rays, rays.saturated);
      if (rays.pending_rays.size() != 0)
         rays.report_mismatch($sformatf("%0d rays never arrived", rays.pending_rays.size()));
      if (rays.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
